// File: rtl/core/mpr_pkg.sv
package mpr_pkg;

	// vector geometry
	localparam int VEC_LEN = 8;
	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 64;
	localparam int PROD_W  = 2 * BYTE_W;
	// one int8 x int8 product needs PROD_W bits; VEC_LEN of them add clog2 bits plus margin
	localparam int DOT_W   = PROD_W + $clog2(VEC_LEN) + 1;

	// accumulator and requantizer widths
	localparam int ACC_W   = 32;
	localparam int MULT_W  = 32;
	localparam int WIDE_W  = ACC_W + MULT_W;
	localparam int SHIFT_W = 5;
	localparam int RES_W   = 8;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_MULTIPLIER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELU_ENABLE      = 2'd2;

	// int8 saturation bounds
	localparam logic signed [WIDE_W-1:0] RES_MAX = 64'sd127;
	localparam logic signed [WIDE_W-1:0] RES_MIN = -64'sd128;

	typedef struct packed {
		logic [WORD_W-1:0]       activation_word;
		logic [WORD_W-1:0]       weight_word_even;
		logic [WORD_W-1:0]       weight_word_odd;
		logic signed [ACC_W-1:0] bias_even;
		logic signed [ACC_W-1:0] bias_odd;
		logic                    first_item;
		logic                    last_item;
	} in_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_even;
		logic signed [RES_W-1:0] result_odd;
	} out_t;

	// what one cell hands to its neighbor
	typedef struct packed {
		logic [WORD_W-1:0]       act;
		logic [WORD_W-1:0]       wt_even;
		logic [WORD_W-1:0]       wt_odd;
		logic signed [DOT_W-1:0] psum_even;
		logic signed [DOT_W-1:0] psum_odd;
		logic signed [ACC_W-1:0] bias_even;
		logic signed [ACC_W-1:0] bias_odd;
		logic                    first;
		logic                    last;
	} cell_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] sum_even;
		logic signed [ACC_W-1:0] sum_odd;
	} acc_out_t;

	typedef struct packed {
		logic signed [MULT_W-1:0] scale_multiplier;
		logic [SHIFT_W-1:0]       scale_shift;
		logic                     relu_enable;
	} cfg_t;

endpackage

// File: rtl/core/mpr_cell.sv
// One MAC cell: multiplies the low byte pair of each lane, adds to the
// partial sums and passes the words on shifted down by one byte.
module mpr_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mpr_pkg::cell_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output mpr_pkg::cell_t out_data
);

	logic                                    valid_q;
	mpr_pkg::cell_t                          data_q;
	mpr_pkg::cell_t                          next_data;
	logic signed [mpr_pkg::BYTE_W-1:0]       act_b;
	logic signed [mpr_pkg::BYTE_W-1:0]       we_b;
	logic signed [mpr_pkg::BYTE_W-1:0]       wo_b;
	logic signed [mpr_pkg::PROD_W-1:0]       prod_e;
	logic signed [mpr_pkg::PROD_W-1:0]       prod_o;
	logic [mpr_pkg::DOT_W-mpr_pkg::PROD_W-1:0] ext_e;
	logic [mpr_pkg::DOT_W-mpr_pkg::PROD_W-1:0] ext_o;

	assign act_b  = in_data.act[mpr_pkg::BYTE_W-1:0];
	assign we_b   = in_data.wt_even[mpr_pkg::BYTE_W-1:0];
	assign wo_b   = in_data.wt_odd[mpr_pkg::BYTE_W-1:0];
	assign prod_e = mpr_pkg::PROD_W'(act_b) * mpr_pkg::PROD_W'(we_b);
	assign prod_o = mpr_pkg::PROD_W'(act_b) * mpr_pkg::PROD_W'(wo_b);
	assign ext_e  = {(mpr_pkg::DOT_W-mpr_pkg::PROD_W){prod_e[mpr_pkg::PROD_W-1]}};
	assign ext_o  = {(mpr_pkg::DOT_W-mpr_pkg::PROD_W){prod_o[mpr_pkg::PROD_W-1]}};

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_comb begin
		next_data           = in_data;
		next_data.act       = in_data.act >> mpr_pkg::BYTE_W;
		next_data.wt_even   = in_data.wt_even >> mpr_pkg::BYTE_W;
		next_data.wt_odd    = in_data.wt_odd >> mpr_pkg::BYTE_W;
		next_data.psum_even = in_data.psum_even + $signed({ext_e, prod_e});
		next_data.psum_odd  = in_data.psum_odd + $signed({ext_o, prod_o});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= next_data;
		end
	end

endmodule

// File: rtl/core/mpr_acc.sv
// Lane accumulators: restart from bias on first, add the dot product,
// hand the sums on for requantization on last.
module mpr_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mpr_pkg::cell_t    in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mpr_pkg::acc_out_t out_data
);

	logic signed [mpr_pkg::ACC_W-1:0] sum_even_q;
	logic signed [mpr_pkg::ACC_W-1:0] sum_odd_q;
	logic signed [mpr_pkg::ACC_W-1:0] base_e;
	logic signed [mpr_pkg::ACC_W-1:0] base_o;
	logic signed [mpr_pkg::ACC_W-1:0] next_e;
	logic signed [mpr_pkg::ACC_W-1:0] next_o;
	logic                             valid_s1;
	mpr_pkg::acc_out_t                data_s1;

	assign base_e = in_data.first ? in_data.bias_even : sum_even_q;
	assign base_o = in_data.first ? in_data.bias_odd : sum_odd_q;
	// sums wrap at 32 bits
	assign next_e = base_e + $signed({{(mpr_pkg::ACC_W-mpr_pkg::DOT_W){in_data.psum_even[mpr_pkg::DOT_W-1]}},
		in_data.psum_even});
	assign next_o = base_o + $signed({{(mpr_pkg::ACC_W-mpr_pkg::DOT_W){in_data.psum_odd[mpr_pkg::DOT_W-1]}},
		in_data.psum_odd});

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			sum_even_q <= '0;
			sum_odd_q  <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && in_data.last;
			if (in_valid) begin
				sum_even_q <= next_e;
				sum_odd_q  <= next_o;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && in_data.last) begin
			data_s1.sum_even <= next_e;
			data_s1.sum_odd  <= next_o;
		end
	end

endmodule

// File: rtl/core/mpr_rq.sv
// Requantizer: multiply (s1), add rounding term (s2), shift, ReLU and
// saturate into the output register (s3).
module mpr_rq (
	input  logic              clk,
	input  logic              arst_n,
	input  mpr_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  mpr_pkg::acc_out_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output mpr_pkg::out_t     out_data
);

	logic                              valid_s1, valid_s2, valid_s3;
	logic                              ready_s1, ready_s2, ready_s3;
	logic signed [mpr_pkg::WIDE_W-1:0] prod_e_s1, prod_o_s1;
	logic signed [mpr_pkg::WIDE_W-1:0] x_e_s2, x_o_s2;
	logic [mpr_pkg::WIDE_W-1:0]        rnd;
	mpr_pkg::out_t                     data_s3;

	function automatic logic [mpr_pkg::RES_W-1:0] finish(
		input logic signed [mpr_pkg::WIDE_W-1:0] x,
		input logic [mpr_pkg::SHIFT_W-1:0]       sh,
		input logic                              relu
	);
		logic signed [mpr_pkg::WIDE_W-1:0] y;
		y = x >>> sh;
		if (relu && y < 0) begin
			y = '0;
		end
		if (y > mpr_pkg::RES_MAX) begin
			y = mpr_pkg::RES_MAX;
		end
		if (y < mpr_pkg::RES_MIN) begin
			y = mpr_pkg::RES_MIN;
		end
		return y[mpr_pkg::RES_W-1:0];
	endfunction

	// half an output step; nothing when the shift is zero
	assign rnd = (mpr_pkg::WIDE_W'(1) << cfg.scale_shift) >> 1;

	assign ready_s3  = !valid_s3 || !out_stall;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;
	assign out_valid = valid_s3;
	assign out_data  = data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			// signed 32 x 32 product, sign-extended operands
			prod_e_s1 <= mpr_pkg::WIDE_W'(in_data.sum_even)
				* mpr_pkg::WIDE_W'(cfg.scale_multiplier);
			prod_o_s1 <= mpr_pkg::WIDE_W'(in_data.sum_odd)
				* mpr_pkg::WIDE_W'(cfg.scale_multiplier);
		end
		if (valid_s1 && ready_s2) begin
			x_e_s2 <= prod_e_s1 + $signed(rnd);
			x_o_s2 <= prod_o_s1 + $signed(rnd);
		end
		if (valid_s2 && ready_s3) begin
			data_s3.result_even <= finish(x_e_s2, cfg.scale_shift, cfg.relu_enable);
			data_s3.result_odd  <= finish(x_o_s2, cfg.scale_shift, cfg.relu_enable);
		end
	end

endmodule

// File: rtl/core/int8_mac_pair_requantizer_unit.sv
// Paired int8 dot-product accumulator with requantization.
// Input channel (in_valid / in_stall / in_data): one transfer carries eight
// packed int8 activations, one int8 weight vector per lane (even, odd), the
// lane biases and the first/last flags. Every transfer updates both lane sums;
// a transfer flagged last also yields one output transfer (out_valid /
// out_stall / out_data) with both lanes requantized to int8.
// Datapath: a row of VEC_LEN MAC cells, one per vector element; each cell
// multiplies its byte pair and passes the partial sums to its neighbor. The
// lane accumulators sit behind the last cell, followed by a three-stage
// requantizer (multiply, round, shift/ReLU/saturate).
// Throughput: one input transfer per clock while in_stall is low. An item
// is registered in each cell, then in the accumulators, then in the requantizer stages.
// Stall: every stage has its own valid bit, so bubbles close up; with the
// receiver stalled the pipeline fills and then in_stall rises. A held
// result stays unchanged until taken.
// Reset: both lane sums clear to zero, scale_multiplier goes to 1,
// scale_shift and relu_enable to 0; no items are in flight.
// Configuration: cfg_we writes register cfg_index (0 multiplier, 1 shift,
// 2 ReLU enable) with cfg_data; write only while the unit is idle.
module int8_mac_pair_requantizer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  mpr_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mpr_pkg::out_t                     out_data,
	input  logic                              cfg_we,
	input  logic [mpr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// configuration registers
	logic signed [mpr_pkg::MULT_W-1:0] scale_multiplier_q;
	logic [mpr_pkg::SHIFT_W-1:0]       scale_shift_q;
	logic                              relu_enable_q;
	mpr_pkg::cfg_t                     cfg;

	// cell row links; entry k feeds cell k, entry VEC_LEN feeds the accumulators
	logic [mpr_pkg::VEC_LEN:0] chain_valid;
	logic [mpr_pkg::VEC_LEN:0] chain_ready;
	mpr_pkg::cell_t            chain_data [mpr_pkg::VEC_LEN+1];

	// accumulator to requantizer
	logic              acc_valid;
	logic              acc_ready;
	mpr_pkg::acc_out_t acc_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_multiplier_q <= mpr_pkg::MULT_W'(1);
			scale_shift_q      <= '0;
			relu_enable_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mpr_pkg::REG_SCALE_MULTIPLIER: begin
					scale_multiplier_q <= cfg_data[mpr_pkg::MULT_W-1:0];
				end
				mpr_pkg::REG_SCALE_SHIFT: begin
					scale_shift_q <= cfg_data[mpr_pkg::SHIFT_W-1:0];
				end
				mpr_pkg::REG_RELU_ENABLE: begin
					relu_enable_q <= cfg_data[0];
				end
				default: begin
					// unmapped index: write is dropped
				end
			endcase
		end
	end

	assign cfg.scale_multiplier = scale_multiplier_q;
	assign cfg.scale_shift      = scale_shift_q;
	assign cfg.relu_enable      = relu_enable_q;

	// head of the row: partial sums start at zero
	assign chain_valid[0]          = in_valid;
	assign in_stall                = !chain_ready[0];
	assign chain_data[0].act       = in_data.activation_word;
	assign chain_data[0].wt_even   = in_data.weight_word_even;
	assign chain_data[0].wt_odd    = in_data.weight_word_odd;
	assign chain_data[0].psum_even = '0;
	assign chain_data[0].psum_odd  = '0;
	assign chain_data[0].bias_even = in_data.bias_even;
	assign chain_data[0].bias_odd  = in_data.bias_odd;
	assign chain_data[0].first     = in_data.first_item;
	assign chain_data[0].last      = in_data.last_item;

	for (genvar k = 0; k < mpr_pkg::VEC_LEN; k++) begin : g_cell
		mpr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_data   (chain_data[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_data  (chain_data[k+1])
		);
	end

	mpr_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[mpr_pkg::VEC_LEN]),
		.in_ready  (chain_ready[mpr_pkg::VEC_LEN]),
		.in_data   (chain_data[mpr_pkg::VEC_LEN]),
		.out_valid (acc_valid),
		.out_ready (acc_ready),
		.out_data  (acc_data)
	);

	mpr_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (acc_valid),
		.in_ready  (acc_ready),
		.in_data   (acc_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// the row only pushes back when its first cell is occupied
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> g_cell[0].u_cell.out_valid)
		else $error("input stalled with empty first cell");

	// a requantize request starts only from a last item leaving the row
	a_emit_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(acc_valid) |-> $past(chain_valid[mpr_pkg::VEC_LEN] &&
			chain_data[mpr_pkg::VEC_LEN].last))
		else $error("accumulator emitted without a last item");

endmodule
